@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the allocator RTL.
// Every property is sampled on i_clk and is off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define FFA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check that one condition implies another in the same cycle.
`define FFA_ASSERT_IMPL(label, cond, expr, msg) \
    `FFA_ASSERT(label, (cond) |-> (expr), msg)

`endif

@@ rtl/core/ffa_pkg.sv @@
// Shared types and codes of the first-fit unit allocator.
// No dependencies; used by first_fit_unit_allocator.
`default_nettype none

package ffa_pkg;

    localparam int CMD_W     = 3;
    localparam int OWNER_W   = 16;
    localparam int SIZE_W    = 7;
    localparam int STATUS_W  = 2;
    localparam int START_W   = 6;
    localparam int LENGTH_W  = 7;
    localparam int UCOUNT_W  = 7;

    localparam int RESULT_CAP = 64;
    localparam int RCNT_W     = 7;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_cmd CMD_REQUEST    = 3'd0;
    localparam t_cmd CMD_RELEASE    = 3'd1;
    localparam t_cmd CMD_LIST_FREE  = 3'd2;
    localparam t_cmd CMD_LIST_OWNED = 3'd3;
    localparam t_cmd CMD_FIND       = 3'd4;

    localparam t_status STATUS_OK   = 2'd0;
    localparam t_status STATUS_FAIL = 2'd1;
    localparam t_status STATUS_NONE = 2'd2;

    localparam logic [UCOUNT_W-1:0] UNIT_COUNT_RESET = 7'd64;

    typedef struct packed {
        t_status              status;
        logic [OWNER_W-1:0]   owner;
        logic [START_W-1:0]   start;
        logic [LENGTH_W-1:0]  length;
        logic                 last;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/core/ffa_cell.sv @@
// One unit of the owner map: holds an owner id and takes its neighbor's on shift.
// No package dependencies.
`default_nettype none

module ffa_cell #(
    parameter int OWNER_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_shift,
    input  wire logic [OWNER_BITS-1:0] i_d,
    output logic      [OWNER_BITS-1:0] o_q
);

    logic [OWNER_BITS-1:0] r_owner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner <= '0;
        end else if (i_shift) begin
            r_owner <= i_d;
        end
    end

    assign o_q = r_owner;

endmodule

`default_nettype wire

@@ rtl/core/ffa_ring.sv @@
// Rotating owner map: a chain of ffa_cell, head read at cell 0, write-back at the tail.
// Depends on ffa_cell.
`default_nettype none

module ffa_ring #(
    parameter int MAX_UNITS  = 64,
    parameter int OWNER_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_shift,
    input  wire logic [OWNER_BITS-1:0] i_tail,
    output logic      [OWNER_BITS-1:0] o_head
);

    logic [OWNER_BITS-1:0] w_q [MAX_UNITS];

    for (genvar k = 0; k < MAX_UNITS; k++) begin : g_cell
        logic [OWNER_BITS-1:0] w_d;
        if (k == MAX_UNITS - 1) begin : g_tail
            assign w_d = i_tail;
        end else begin : g_mid
            assign w_d = w_q[k+1];
        end
        ffa_cell #(
            .OWNER_BITS(OWNER_BITS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_shift(i_shift),
            .i_d    (w_d),
            .o_q    (w_q[k])
        );
    end

    assign o_head = w_q[0];

endmodule

`default_nettype wire

@@ rtl/core/first_fit_unit_allocator.sv @@
// Every command except an unknown one rotates the owner map once through the scan
// unit, one unit per cycle while the rotation is not paused. A failed request, a
// release or a find posts its result after that one rotation. A list posts its final
// result after a further closing step that closes a run that reaches the end of the
// map. A granted request rotates twice (find the run, then fill it).
// An unknown command skips the rotation and posts its failure directly. List
// commands also pause the rotation whenever a run is ready and the result register
// is still held by the consumer, and every command waits for a held result before
// posting its last one. The input is ready again in the same cycle as the final
// result shows at the output. The map clears at reset.
// Depends on ffa_pkg, ffa_ring and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module first_fit_unit_allocator #(
    parameter int MAX_UNITS  = 64,
    parameter int OWNER_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [ffa_pkg::CMD_W-1:0]       i_command,
    input  wire logic [ffa_pkg::OWNER_W-1:0]     i_owner_id,
    input  wire logic [ffa_pkg::SIZE_W-1:0]      i_request_size,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic      [ffa_pkg::STATUS_W-1:0]    o_status,
    output logic      [ffa_pkg::OWNER_W-1:0]     o_run_owner,
    output logic      [ffa_pkg::START_W-1:0]     o_run_start,
    output logic      [ffa_pkg::LENGTH_W-1:0]    o_run_length,
    output logic                                 o_last,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [ffa_pkg::UCOUNT_W-1:0]    i_cfg_unit_count
);

    localparam int IW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int CW = $clog2(MAX_UNITS + 1);
    localparam int LW = (CW > 7) ? CW : 7;
    localparam int OB = OWNER_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_FILL = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    localparam logic [IW-1:0] IDX_LAST = IW'(MAX_UNITS - 1);
    localparam logic [LW-1:0] N_MAX    = LW'(MAX_UNITS);
    localparam logic [ffa_pkg::RCNT_W-1:0] CAP = ffa_pkg::RCNT_W'(ffa_pkg::RESULT_CAP);

    logic [ffa_pkg::UCOUNT_W-1:0] r_unit_count;
    logic [2:0]                   r_state, n_state;
    logic [IW-1:0]                r_idx, n_idx;
    ffa_pkg::t_cmd                r_cmd, n_cmd;
    logic [OB-1:0]                r_owner, n_owner;
    logic [ffa_pkg::SIZE_W-1:0]   r_size, n_size;
    logic [LW-1:0]                r_n, n_n;
    logic                         r_ok, n_ok;
    logic [LW-1:0]                r_run, n_run;
    logic                         r_found, n_found;
    logic [LW-1:0]                r_start, n_start;
    logic [LW-1:0]                r_cnt, n_cnt;
    logic                         r_in_run, n_in_run;
    logic                         r_ra, n_ra;
    logic [OB-1:0]                r_rwho, n_rwho;
    logic [LW-1:0]                r_rstart, n_rstart;
    logic [LW-1:0]                r_rlen, n_rlen;
    logic                         r_hp, n_hp;
    logic [OB-1:0]                r_pwho, n_pwho;
    logic [LW-1:0]                r_pstart, n_pstart;
    logic [LW-1:0]                r_plen, n_plen;
    logic [ffa_pkg::RCNT_W-1:0]   r_fin_cnt, n_fin_cnt;
    ffa_pkg::t_result             r_out, n_out;
    logic                         r_out_valid, n_out_valid;

    logic                  w_shift;
    logic [OB-1:0]         w_head, w_tail;
    logic [LW-1:0]         w_idx_l, w_uc_ext, w_n_cur, w_run_next;
    logic                  w_in_range, w_slot, w_match;
    logic                  w_want_free, w_qual, w_ends, w_push;
    logic [ffa_pkg::RCNT_W-1:0] w_fc_next;
    logic [OB+15:0]        w_in_own_ext;
    logic [OB-1:0]         w_in_owner;
    logic [OB+15:0]        w_own_ext, w_pwho_ext;
    logic                  w_in_acc;

    ffa_ring #(
        .MAX_UNITS (MAX_UNITS),
        .OWNER_BITS(OB)
    ) u_ring (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_shift(w_shift),
        .i_tail (w_tail),
        .o_head (w_head)
    );

    assign w_in_own_ext = {{OB{1'b0}}, i_owner_id};
    assign w_in_owner   = w_in_own_ext[OB-1:0];
    assign w_own_ext    = {16'b0, r_owner};
    assign w_pwho_ext   = {16'b0, r_pwho};

    assign w_uc_ext   = LW'(r_unit_count);
    assign w_n_cur    = (w_uc_ext > N_MAX) ? N_MAX : w_uc_ext;
    assign w_idx_l    = LW'(r_idx);
    assign w_in_range = w_idx_l < r_n;
    assign w_slot     = !r_out_valid || i_out_ready;
    assign w_match    = r_ok && w_in_range && (w_head == r_owner);
    assign w_run_next = (w_head == '0) ? r_run + LW'(1) : '0;

    assign w_want_free = (r_cmd == ffa_pkg::CMD_LIST_FREE);
    assign w_qual      = w_in_range && ((w_head == '0) == w_want_free);
    assign w_ends      = r_ra && (!w_in_range || (w_head != r_rwho));
    assign w_push      = w_ends && r_hp;
    assign w_fc_next   = r_fin_cnt + ffa_pkg::RCNT_W'(w_ends);

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_cmd     = r_cmd;
        n_owner   = r_owner;
        n_size    = r_size;
        n_n       = r_n;
        n_ok      = r_ok;
        n_run     = r_run;
        n_found   = r_found;
        n_start   = r_start;
        n_cnt     = r_cnt;
        n_in_run  = r_in_run;
        n_ra      = r_ra;
        n_rwho    = r_rwho;
        n_rstart  = r_rstart;
        n_rlen    = r_rlen;
        n_hp      = r_hp;
        n_pwho    = r_pwho;
        n_pstart  = r_pstart;
        n_plen    = r_plen;
        n_fin_cnt = r_fin_cnt;
        n_out     = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        w_shift   = 1'b0;
        w_tail    = w_head;

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_cmd     = i_command;
                    n_owner   = w_in_owner;
                    n_size    = i_request_size;
                    n_n       = w_n_cur;
                    n_idx     = '0;
                    n_run     = '0;
                    n_found   = 1'b0;
                    n_start   = '0;
                    n_cnt     = '0;
                    n_in_run  = 1'b0;
                    n_ra      = 1'b0;
                    n_hp      = 1'b0;
                    n_fin_cnt = '0;
                    if (i_command == ffa_pkg::CMD_REQUEST) begin
                        n_ok = (w_in_owner != '0) && (i_request_size != '0)
                               && (LW'(i_request_size) <= w_n_cur);
                    end else begin
                        n_ok = (w_in_owner != '0);
                    end
                    if (i_command <= ffa_pkg::CMD_FIND) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_SCAN: begin
                // List commands stall while a finished run cannot be posted
                if (!(((r_cmd == ffa_pkg::CMD_LIST_FREE) ||
                       (r_cmd == ffa_pkg::CMD_LIST_OWNED)) && w_push && !w_slot)) begin
                    w_shift = 1'b1;
                    case (r_cmd)
                        ffa_pkg::CMD_REQUEST: begin
                            if (r_ok && !r_found && w_in_range) begin
                                n_run = w_run_next;
                                if (w_run_next == LW'(r_size)) begin
                                    n_found = 1'b1;
                                    n_start = w_idx_l + LW'(1) - LW'(r_size);
                                end
                            end
                        end
                        ffa_pkg::CMD_RELEASE: begin
                            if (w_match) begin
                                w_tail = '0;
                                n_cnt  = r_cnt + LW'(1);
                            end
                        end
                        ffa_pkg::CMD_FIND: begin
                            if (!r_found && w_match) begin
                                n_found  = 1'b1;
                                n_start  = w_idx_l;
                                n_cnt    = LW'(1);
                                n_in_run = 1'b1;
                            end else if (r_in_run && w_match) begin
                                n_cnt = r_cnt + LW'(1);
                            end else begin
                                n_in_run = 1'b0;
                            end
                        end
                        ffa_pkg::CMD_LIST_FREE, ffa_pkg::CMD_LIST_OWNED: begin
                            if (w_push) begin
                                n_out_valid = 1'b1;
                                n_out = '{status: ffa_pkg::STATUS_OK,
                                          owner:  w_pwho_ext[15:0],
                                          start:  r_pstart[5:0],
                                          length: r_plen[6:0],
                                          last:   1'b0};
                            end
                            if (w_ends) begin
                                n_hp      = 1'b1;
                                n_pwho    = r_rwho;
                                n_pstart  = r_rstart;
                                n_plen    = r_rlen;
                                n_ra      = 1'b0;
                                n_fin_cnt = w_fc_next;
                            end
                            if (r_ra && !w_ends) begin
                                n_rlen = r_rlen + LW'(1);
                            end else if (w_qual && (w_fc_next < CAP)) begin
                                n_ra     = 1'b1;
                                n_rwho   = w_head;
                                n_rstart = w_idx_l;
                                n_rlen   = LW'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (r_idx == IDX_LAST) begin
                        n_idx = '0;
                        if ((r_cmd == ffa_pkg::CMD_REQUEST) && n_found) begin
                            n_state = ST_FILL;
                        end else if ((r_cmd == ffa_pkg::CMD_LIST_FREE) ||
                                     (r_cmd == ffa_pkg::CMD_LIST_OWNED)) begin
                            n_state = ST_FIN;
                        end else begin
                            n_state = ST_EMIT;
                        end
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            ST_FILL: begin
                w_shift = 1'b1;
                if ((w_idx_l >= r_start) && ((w_idx_l - r_start) < LW'(r_size))) begin
                    w_tail = r_owner;
                end
                if (r_idx == IDX_LAST) begin
                    n_idx   = '0;
                    n_state = ST_EMIT;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            ST_FIN: begin
                // Close a run that reaches the end of the map
                if (!(r_ra && r_hp) || w_slot) begin
                    if (r_ra && r_hp) begin
                        n_out_valid = 1'b1;
                        n_out = '{status: ffa_pkg::STATUS_OK,
                                  owner:  w_pwho_ext[15:0],
                                  start:  r_pstart[5:0],
                                  length: r_plen[6:0],
                                  last:   1'b0};
                    end
                    if (r_ra) begin
                        n_hp     = 1'b1;
                        n_pwho   = r_rwho;
                        n_pstart = r_rstart;
                        n_plen   = r_rlen;
                        n_ra     = 1'b0;
                    end
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    case (r_cmd)
                        ffa_pkg::CMD_REQUEST: begin
                            n_out = '{status: r_found ? ffa_pkg::STATUS_OK
                                                      : ffa_pkg::STATUS_FAIL,
                                      owner:  w_own_ext[15:0],
                                      start:  r_found ? r_start[5:0] : 6'd0,
                                      length: r_size,
                                      last:   1'b1};
                        end
                        ffa_pkg::CMD_RELEASE: begin
                            n_out = '{status: (r_cnt != '0) ? ffa_pkg::STATUS_OK
                                                            : ffa_pkg::STATUS_FAIL,
                                      owner:  w_own_ext[15:0],
                                      start:  6'd0,
                                      length: r_cnt[6:0],
                                      last:   1'b1};
                        end
                        ffa_pkg::CMD_FIND: begin
                            n_out = '{status: !r_ok    ? ffa_pkg::STATUS_FAIL :
                                              r_found  ? ffa_pkg::STATUS_OK
                                                       : ffa_pkg::STATUS_NONE,
                                      owner:  w_own_ext[15:0],
                                      start:  r_found ? r_start[5:0] : 6'd0,
                                      length: r_found ? r_cnt[6:0] : 7'd0,
                                      last:   1'b1};
                        end
                        ffa_pkg::CMD_LIST_FREE, ffa_pkg::CMD_LIST_OWNED: begin
                            n_out = '{status: r_hp ? ffa_pkg::STATUS_OK
                                                   : ffa_pkg::STATUS_NONE,
                                      owner:  r_hp ? w_pwho_ext[15:0] : 16'd0,
                                      start:  r_hp ? r_pstart[5:0] : 6'd0,
                                      length: r_hp ? r_plen[6:0] : 7'd0,
                                      last:   1'b1};
                        end
                        default: begin
                            n_out = '{status: ffa_pkg::STATUS_FAIL,
                                      owner:  16'd0,
                                      start:  6'd0,
                                      length: 7'd0,
                                      last:   1'b1};
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
            r_unit_count <= ffa_pkg::UNIT_COUNT_RESET;
            r_found      <= 1'b0;
            r_fin_cnt    <= '0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            r_found     <= n_found;
            r_fin_cnt   <= n_fin_cnt;
            if (i_cfg_valid && o_cfg_ready) begin
                r_unit_count <= i_cfg_unit_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_owner  <= n_owner;
        r_size   <= n_size;
        r_n      <= n_n;
        r_ok     <= n_ok;
        r_run    <= n_run;
        r_start  <= n_start;
        r_cnt    <= n_cnt;
        r_in_run <= n_in_run;
        r_ra     <= n_ra;
        r_rwho   <= n_rwho;
        r_rstart <= n_rstart;
        r_rlen   <= n_rlen;
        r_hp     <= n_hp;
        r_pwho   <= n_pwho;
        r_pstart <= n_pstart;
        r_plen   <= n_plen;
        r_out    <= n_out;
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out.status;
    assign o_run_owner  = r_out.owner;
    assign o_run_start  = r_out.start;
    assign o_run_length = r_out.length;
    assign o_last       = r_out.last;

    `FFA_ASSERT_IMPL(a_idle_aligned, r_state == ST_IDLE, r_idx == '0, "map not aligned in idle")
    `FFA_ASSERT_IMPL(a_fill_found, r_state == ST_FILL, r_found, "fill pass without a run")
    `FFA_ASSERT(a_cap, r_fin_cnt <= CAP, "list result count beyond cap")

endmodule

`default_nettype wire
